>>> rtl/htw_pkg.sv
// shared codes and types for the hashed timer wheel
// no dependencies; imported by the slot memory, the top level and the testbench

package htw_pkg;

  localparam logic [1:0] CMD_INSERT  = 2'd0;
  localparam logic [1:0] CMD_CANCEL  = 2'd1;
  localparam logic [1:0] CMD_RESCHED = 2'd2;
  localparam logic [1:0] CMD_TICK    = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_DEAD = 2'd2;
  localparam logic [1:0] ST_ZERO = 2'd3;

  // per-field write enables of the slot record memory
  typedef struct packed {
    logic time_en;
    logic tag_en;
    logic next_en;
    logic prev_en;
  } slot_wmask_t;

endpackage

>>> rtl/htw_slot_mem.sv
// slot record memory: expiry time, tag and list links per timer slot
// depends on htw_pkg for the field write mask

module htw_slot_mem import htw_pkg::*; #(
  parameter int DEPTH     = 64,
  parameter int TIME_BITS = 32,
  parameter int PTR_W     = 7,
  localparam int AW       = $clog2(DEPTH)
) (
  input  logic                 clk_i,
  input  logic                 rd_en_i,
  input  logic [AW-1:0]        rd_addr_i,
  output logic [TIME_BITS-1:0] rd_time_o,
  output logic [31:0]          rd_tag_o,
  output logic [PTR_W-1:0]     rd_next_o,
  output logic [PTR_W-1:0]     rd_prev_o,
  input  logic                 wr_en_i,
  input  slot_wmask_t          wr_mask_i,
  input  logic [AW-1:0]        wr_addr_i,
  input  logic [TIME_BITS-1:0] wr_time_i,
  input  logic [31:0]          wr_tag_i,
  input  logic [PTR_W-1:0]     wr_next_i,
  input  logic [PTR_W-1:0]     wr_prev_i
);

  logic [TIME_BITS-1:0] time_mem [DEPTH];
  logic [31:0]          tag_mem  [DEPTH];
  logic [PTR_W-1:0]     next_mem [DEPTH];
  logic [PTR_W-1:0]     prev_mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      if (wr_mask_i.time_en) time_mem[wr_addr_i] <= wr_time_i;
      if (wr_mask_i.tag_en)  tag_mem[wr_addr_i]  <= wr_tag_i;
      if (wr_mask_i.next_en) next_mem[wr_addr_i] <= wr_next_i;
      if (wr_mask_i.prev_en) prev_mem[wr_addr_i] <= wr_prev_i;
    end
    if (rd_en_i) begin
      rd_time_o <= time_mem[rd_addr_i];
      rd_tag_o  <= tag_mem[rd_addr_i];
      rd_next_o <= next_mem[rd_addr_i];
      rd_prev_o <= prev_mem[rd_addr_i];
    end
  end

endmodule

>>> rtl/htw_bucket_mem.sv
// bucket memory: head and tail slot pointer of every wheel bucket
// no dependencies

module htw_bucket_mem #(
  parameter int DEPTH = 1024,
  parameter int PTR_W = 7,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [PTR_W-1:0] rd_head_o,
  output logic [PTR_W-1:0] rd_tail_o,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [PTR_W-1:0] wr_head_i,
  input  logic [PTR_W-1:0] wr_tail_i
);

  logic [2*PTR_W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) mem[wr_addr_i] <= {wr_head_i, wr_tail_i};
    if (rd_en_i) {rd_head_o, rd_tail_o} <= mem[rd_addr_i];
  end

endmodule

>>> rtl/htw_hash.sv
// bucket hash: (time >> shift) mod buckets
// no dependencies; a registered bit select for a power-of-two wheel, else four bits per cycle

module htw_hash #(
  parameter int TIME_BITS    = 32,
  parameter int BUCKETS      = 1024,
  parameter int BUCKET_SHIFT = 5,
  localparam int BW          = $clog2(BUCKETS)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [TIME_BITS-1:0] value_i,
  output logic                 done_o,
  output logic [BW-1:0]        bucket_o
);

  localparam bit POW2 = (BUCKETS & (BUCKETS - 1)) == 0;

  logic done_q;
  assign done_o = done_q;

  if (POW2) begin : g_mask
    logic [BW-1:0] bkt_q;
    assign bucket_o = bkt_q;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        done_q <= 1'b0;
      end else begin
        done_q <= start_i;
      end
    end

    always_ff @(posedge clk_i) begin
      if (start_i) bkt_q <= BW'(value_i >> BUCKET_SHIFT);
    end
  end else begin : g_serial
    // one hex digit per cycle, remainder reduced by compare and subtract
    localparam int ND = (TIME_BITS + 3) / 4;
    localparam int XW = 4 * ND;
    localparam int RW = BW + 4;
    localparam int CW = $clog2(ND + 1);

    logic [XW-1:0] x_q;
    logic [BW-1:0] r_q;
    logic [CW-1:0] cnt_q;
    logic          busy_q;
    logic [RW-1:0] r16;
    logic [BW-1:0] r_next;

    assign r16      = {r_q, x_q[XW-1 -: 4]};
    assign bucket_o = r_q;

    // r16 less the largest multiple of the bucket count not above r16
    always_comb begin
      r_next = r16[BW-1:0];
      for (int k = 1; k < 16; k++) begin
        if (r16 >= RW'(k * BUCKETS)) r_next = BW'(r16 - RW'(k * BUCKETS));
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        busy_q <= 1'b0;
        done_q <= 1'b0;
        cnt_q  <= '0;
      end else begin
        done_q <= 1'b0;
        if (start_i) begin
          busy_q <= 1'b1;
          cnt_q  <= CW'(ND);
        end else if (busy_q) begin
          cnt_q <= cnt_q - CW'(1);
          if (cnt_q == CW'(1)) begin
            busy_q <= 1'b0;
            done_q <= 1'b1;
          end
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (start_i) begin
        x_q <= XW'(value_i >> BUCKET_SHIFT);
        r_q <= '0;
      end else if (busy_q) begin
        x_q <= x_q << 4;
        r_q <= r_next;
      end
    end
  end

endmodule

>>> rtl/hashed_timer_wheel_unit.sv
// hashed timer wheel: top level with command sequencer and output register
// depends on htw_pkg, htw_slot_mem, htw_bucket_mem and htw_hash
//
// channel  dir  group   fields (lowest bit first)
// command  in   s_axis  tuser: command[1:0]
//                       tdata: handle[5:0] delay[36:6] elapsed[68:37] tag[100:69]
// result   out  m_axis  tuser: status[1:0] expired[2]
//                       tdata: out_handle[5:0] out_tag[37:6]; tlast: last
//
// one command is worked on at a time; the sequencer walks lists through the
// slot memory and bucket memory, one access each per cycle, with registered read data
// insert: hash, bucket read, walk along the list to the first later entry, link writes
// cancel: slot read, hash, bucket read, neighbor writes; reschedule: cancel plus insert
// tick: hash unless elapsed spans the wheel, then a bucket read per bucket visited
// and an unlink per expired timer; hash is serial unless BUCKETS is a power of two
// after reset a clearing pass nulls the buckets, tready low
// a full output register stalls the sequencer at the next result

module hashed_timer_wheel_unit import htw_pkg::*; #(
  parameter int POOL_SIZE    = 64,
  parameter int BUCKETS      = 1024,
  parameter int BUCKET_SHIFT = 5,
  parameter int TIME_BITS    = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [103:0] s_axis_tdata_i,  // handle, delay, elapsed, tag, zero fill
  input  logic [1:0]   s_axis_tuser_i,  // command
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [39:0]  m_axis_tdata_o,  // out_handle, out_tag, zero fill
  output logic [2:0]   m_axis_tuser_o,  // status, expired
  output logic         m_axis_tlast_o   // last
);

  localparam int SW    = $clog2(POOL_SIZE);
  localparam int PW    = $clog2(POOL_SIZE + 1);
  localparam int BW    = $clog2(BUCKETS);
  localparam int SUM_W = (TIME_BITS > 32 ? TIME_BITS : 32) + 1;
  localparam logic [PW-1:0]        NIL      = PW'(POOL_SIZE);
  localparam logic [TIME_BITS-1:0] TIME_MAX = '1;
  localparam logic [BW-1:0]        LAST_BKT = BW'(BUCKETS - 1);
  localparam logic [32:0]          BKT_X    = 33'(BUCKETS);

  // sequencer states
  localparam logic [4:0] S_CLR      = 5'd0;
  localparam logic [4:0] S_IDLE     = 5'd1;
  localparam logic [4:0] S_EMIT     = 5'd2;
  localparam logic [4:0] S_INS_HASH = 5'd3;
  localparam logic [4:0] S_L_WB     = 5'd4;
  localparam logic [4:0] S_L_WS     = 5'd5;
  localparam logic [4:0] S_L_END1   = 5'd6;
  localparam logic [4:0] S_L_END2   = 5'd7;
  localparam logic [4:0] S_L_MID1   = 5'd8;
  localparam logic [4:0] S_L_MID2   = 5'd9;
  localparam logic [4:0] S_L_MID3   = 5'd10;
  localparam logic [4:0] S_U_WS     = 5'd11;
  localparam logic [4:0] S_U_HASH   = 5'd12;
  localparam logic [4:0] S_U_WB     = 5'd13;
  localparam logic [4:0] S_U_W2     = 5'd14;
  localparam logic [4:0] S_T_HASH   = 5'd15;
  localparam logic [4:0] S_T_RDB    = 5'd16;
  localparam logic [4:0] S_T_WB     = 5'd17;
  localparam logic [4:0] S_T_WS     = 5'd18;
  localparam logic [4:0] S_T_PUSH   = 5'd19;
  localparam logic [4:0] S_T_NEXTB  = 5'd20;

  function automatic logic [TIME_BITS-1:0] sat_add(input logic [TIME_BITS-1:0] a,
                                                   input logic [31:0] b);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(a) + SUM_W'(b);
    if (sum > SUM_W'(TIME_MAX)) return TIME_MAX;
    return sum[TIME_BITS-1:0];
  endfunction

  // input transaction fields
  logic [1:0]  in_cmd;
  logic [5:0]  in_handle;
  logic [30:0] in_delay;
  logic [31:0] in_elapsed;
  logic [31:0] in_tag;
  assign in_cmd     = s_axis_tuser_i;
  assign in_handle  = s_axis_tdata_i[5:0];
  assign in_delay   = s_axis_tdata_i[36:6];
  assign in_elapsed = s_axis_tdata_i[68:37];
  assign in_tag     = s_axis_tdata_i[100:69];

  // control state
  logic [4:0]           state_q, state_d;
  logic [BW-1:0]        clr_q, clr_d;
  logic [TIME_BITS-1:0] now_q, now_d;
  logic [BW-1:0]        scan_q, scan_d;
  logic [POOL_SIZE-1:0] live_q, live_d;
  logic                 pend_q, pend_d;
  logic                 m_valid_q;

  // working registers of the current command
  logic [1:0]           cmd_q, cmd_d;
  logic [SW-1:0]        s_q, s_d;
  logic [TIME_BITS-1:0] nt_q, nt_d;
  logic [31:0]          tag_q, tag_d;
  logic [BW-1:0]        b_q, b_d;
  logic [BW-1:0]        stop_q, stop_d;
  logic                 over_q, over_d;
  logic                 first_q, first_d;
  logic [PW-1:0]        bh_q, bh_d, bt_q, bt_d;
  logic [PW-1:0]        p_q, p_d, pp_q, pp_d;
  logic [PW-1:0]        sn_q, sn_d, sp_q, sp_d;
  logic [31:0]          ex_tag_q, ex_tag_d;

  // pending result, sent once the next one (or the end) is known
  logic [1:0]           res_st_q, res_st_d;
  logic [SW-1:0]        res_hdl_q, res_hdl_d;
  logic [31:0]          res_tag_q, res_tag_d;
  logic                 res_exp_q, res_exp_d;

  // output register payload
  logic [1:0]           m_st_q;
  logic [SW-1:0]        m_hdl_q;
  logic [31:0]          m_tag_q;
  logic                 m_exp_q, m_last_q;
  logic                 out_load, out_last, out_free;

  // memory ports
  logic                 sr_en, sw_en;
  logic [SW-1:0]        sr_addr, sw_addr;
  slot_wmask_t          sw_mask;
  logic [TIME_BITS-1:0] sw_time, sr_time;
  logic [31:0]          sw_tag, sr_tag;
  logic [PW-1:0]        sw_next, sw_prev, sr_next, sr_prev;
  logic                 br_en, bw_en;
  logic [BW-1:0]        br_addr, bw_addr;
  logic [PW-1:0]        br_head, br_tail, bw_head, bw_tail;

  logic                 hash_start, hash_done;
  logic [TIME_BITS-1:0] hash_val;
  logic [BW-1:0]        hash_bkt;

  logic [SW-1:0]        free_idx;
  logic                 hdl_ok, link_done;
  logic [TIME_BITS-1:0] nt_in, now_tick;
  logic                 over_in;
  logic [PW-1:0]        s_ptr, tail_after;

  htw_slot_mem #(
    .DEPTH(POOL_SIZE), .TIME_BITS(TIME_BITS), .PTR_W(PW)
  ) u_slot_mem (
    .clk_i, .rd_en_i(sr_en), .rd_addr_i(sr_addr),
    .rd_time_o(sr_time), .rd_tag_o(sr_tag), .rd_next_o(sr_next), .rd_prev_o(sr_prev),
    .wr_en_i(sw_en), .wr_mask_i(sw_mask), .wr_addr_i(sw_addr),
    .wr_time_i(sw_time), .wr_tag_i(sw_tag), .wr_next_i(sw_next), .wr_prev_i(sw_prev)
  );

  htw_bucket_mem #(.DEPTH(BUCKETS), .PTR_W(PW)) u_bucket_mem (
    .clk_i, .rd_en_i(br_en), .rd_addr_i(br_addr),
    .rd_head_o(br_head), .rd_tail_o(br_tail),
    .wr_en_i(bw_en), .wr_addr_i(bw_addr), .wr_head_i(bw_head), .wr_tail_i(bw_tail)
  );

  htw_hash #(
    .TIME_BITS(TIME_BITS), .BUCKETS(BUCKETS), .BUCKET_SHIFT(BUCKET_SHIFT)
  ) u_hash (
    .clk_i, .rst_ni, .start_i(hash_start), .value_i(hash_val),
    .done_o(hash_done), .bucket_o(hash_bkt)
  );

  // lowest free slot
  always_comb begin
    free_idx = '0;
    for (int i = POOL_SIZE - 1; i >= 0; i--) begin
      if (!live_q[i]) free_idx = SW'(i);
    end
  end

  assign hdl_ok   = ({1'b0, in_handle} < 7'(POOL_SIZE)) && live_q[in_handle[SW-1:0]];
  assign nt_in    = sat_add(now_q, {1'b0, in_delay});
  assign now_tick = sat_add(now_q, in_elapsed);
  assign over_in  = ((33'(in_elapsed) >> BUCKET_SHIFT) >= BKT_X);
  assign s_ptr    = PW'(s_q);
  // tail once the head is taken off
  assign tail_after = (bt_q == bh_q) ? NIL : bt_q;
  assign out_free = !m_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;   clr_d = clr_q;     now_d = now_q;     scan_d = scan_q;
    live_d = live_q;     pend_d = pend_q;   cmd_d = cmd_q;     s_d = s_q;
    nt_d = nt_q;         tag_d = tag_q;     b_d = b_q;         stop_d = stop_q;
    over_d = over_q;     first_d = first_q; bh_d = bh_q;       bt_d = bt_q;
    p_d = p_q;           pp_d = pp_q;       sn_d = sn_q;       sp_d = sp_q;
    ex_tag_d = ex_tag_q;
    res_st_d = res_st_q; res_hdl_d = res_hdl_q; res_tag_d = res_tag_q; res_exp_d = res_exp_q;
    sr_en = 1'b0;  sr_addr = s_q;
    sw_en = 1'b0;  sw_addr = s_q;  sw_mask = '0;
    sw_time = nt_q; sw_tag = tag_q; sw_next = NIL; sw_prev = NIL;
    br_en = 1'b0;  br_addr = b_q;
    bw_en = 1'b0;  bw_addr = b_q;  bw_head = NIL; bw_tail = NIL;
    hash_start = 1'b0; hash_val = nt_q;
    out_load = 1'b0;  out_last = 1'b0;
    link_done = 1'b0;

    unique case (state_q)
      S_CLR: begin
        bw_en   = 1'b1;
        bw_addr = clr_q;
        if (clr_q == LAST_BKT) state_d = S_IDLE;
        else clr_d = clr_q + BW'(1);
      end
      S_IDLE: begin
        if (s_axis_tvalid_i) begin
          cmd_d     = in_cmd;
          tag_d     = in_tag;
          res_hdl_d = '0;
          res_tag_d = '0;
          res_exp_d = 1'b0;
          unique case (in_cmd)
            CMD_INSERT: begin
              if (in_delay == '0) begin
                res_st_d = ST_ZERO;
                state_d  = S_EMIT;
              end else if (&live_q) begin
                res_st_d = ST_FULL;
                state_d  = S_EMIT;
              end else begin
                s_d              = free_idx;
                live_d[free_idx] = 1'b1;
                nt_d             = nt_in;
                hash_start       = 1'b1;
                hash_val         = nt_in;
                state_d          = S_INS_HASH;
              end
            end
            CMD_CANCEL, CMD_RESCHED: begin
              if (!hdl_ok) begin
                res_st_d = ST_DEAD;
                state_d  = S_EMIT;
              end else if (in_cmd == CMD_RESCHED && in_delay == '0) begin
                res_st_d = ST_ZERO;
                state_d  = S_EMIT;
              end else begin
                s_d     = in_handle[SW-1:0];
                nt_d    = nt_in;
                sr_en   = 1'b1;
                sr_addr = in_handle[SW-1:0];
                state_d = S_U_WS;
              end
            end
            CMD_TICK: begin
              now_d   = now_tick;
              over_d  = over_in;
              b_d     = scan_q;
              first_d = 1'b1;
              pend_d  = 1'b0;
              if (over_in) begin
                stop_d  = scan_q;
                state_d = S_T_RDB;
              end else begin
                hash_start = 1'b1;
                hash_val   = now_tick;
                state_d    = S_T_HASH;
              end
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          out_last = 1'b1;
          state_d  = S_IDLE;
        end
      end
      // sorted insert: find the first entry with a later time
      S_INS_HASH: begin
        if (hash_done) begin
          b_d     = hash_bkt;
          br_en   = 1'b1;
          br_addr = hash_bkt;
          state_d = S_L_WB;
        end
      end
      S_L_WB: begin
        bh_d = br_head;
        bt_d = br_tail;
        if (br_head == NIL) begin
          state_d = S_L_END1;
        end else begin
          sr_en   = 1'b1;
          sr_addr = br_head[SW-1:0];
          p_d     = br_head;
          state_d = S_L_WS;
        end
      end
      S_L_WS: begin
        if (sr_time <= nt_q) begin
          if (sr_next == NIL) begin
            state_d = S_L_END1;
          end else begin
            p_d     = sr_next;
            sr_en   = 1'b1;
            sr_addr = sr_next[SW-1:0];
          end
        end else begin
          pp_d    = sr_prev;
          state_d = S_L_MID1;
        end
      end
      S_L_END1: begin
        sw_en   = 1'b1;
        sw_mask = '{time_en: 1'b1, tag_en: (cmd_q == CMD_INSERT), next_en: 1'b1,
                    prev_en: 1'b1};
        sw_next = NIL;
        sw_prev = bt_q;
        bw_en   = 1'b1;
        bw_head = (bt_q != NIL) ? bh_q : s_ptr;
        bw_tail = s_ptr;
        if (bt_q != NIL) state_d = S_L_END2;
        else link_done = 1'b1;
      end
      S_L_END2: begin
        sw_en   = 1'b1;
        sw_addr = bt_q[SW-1:0];
        sw_mask = '{time_en: 1'b0, tag_en: 1'b0, next_en: 1'b1, prev_en: 1'b0};
        sw_next = s_ptr;
        link_done = 1'b1;
      end
      S_L_MID1: begin
        sw_en   = 1'b1;
        sw_mask = '{time_en: 1'b1, tag_en: (cmd_q == CMD_INSERT), next_en: 1'b1,
                    prev_en: 1'b1};
        sw_next = p_q;
        sw_prev = pp_q;
        if (pp_q == NIL) begin
          bw_en   = 1'b1;
          bw_head = s_ptr;
          bw_tail = bt_q;
        end
        state_d = S_L_MID2;
      end
      S_L_MID2: begin
        sw_en   = 1'b1;
        sw_addr = p_q[SW-1:0];
        sw_mask = '{time_en: 1'b0, tag_en: 1'b0, next_en: 1'b0, prev_en: 1'b1};
        sw_prev = s_ptr;
        if (pp_q != NIL) state_d = S_L_MID3;
        else link_done = 1'b1;
      end
      S_L_MID3: begin
        sw_en   = 1'b1;
        sw_addr = pp_q[SW-1:0];
        sw_mask = '{time_en: 1'b0, tag_en: 1'b0, next_en: 1'b1, prev_en: 1'b0};
        sw_next = s_ptr;
        link_done = 1'b1;
      end
      // unlink: neighbors and bucket ends skip over the slot
      S_U_WS: begin
        sn_d       = sr_next;
        sp_d       = sr_prev;
        hash_start = 1'b1;
        hash_val   = sr_time;
        state_d    = S_U_HASH;
      end
      S_U_HASH: begin
        if (hash_done) begin
          b_d     = hash_bkt;
          br_en   = 1'b1;
          br_addr = hash_bkt;
          state_d = S_U_WB;
        end
      end
      S_U_WB: begin
        bw_en   = 1'b1;
        bw_head = (br_head == s_ptr) ? sn_q : br_head;
        bw_tail = (br_tail == s_ptr) ? sp_q : br_tail;
        if (sp_q != NIL) begin
          sw_en   = 1'b1;
          sw_addr = sp_q[SW-1:0];
          sw_mask = '{time_en: 1'b0, tag_en: 1'b0, next_en: 1'b1, prev_en: 1'b0};
          sw_next = sn_q;
        end
        state_d = S_U_W2;
      end
      S_U_W2: begin
        if (sn_q != NIL) begin
          sw_en   = 1'b1;
          sw_addr = sn_q[SW-1:0];
          sw_mask = '{time_en: 1'b0, tag_en: 1'b0, next_en: 1'b0, prev_en: 1'b1};
          sw_prev = sp_q;
        end
        if (cmd_q == CMD_CANCEL) begin
          live_d[s_q] = 1'b0;
          res_st_d    = ST_OK;
          state_d     = S_EMIT;
        end else begin
          hash_start = 1'b1;
          hash_val   = nt_q;
          state_d    = S_INS_HASH;
        end
      end
      // tick: drain expired heads bucket by bucket
      S_T_HASH: begin
        if (hash_done) begin
          stop_d  = hash_bkt;
          scan_d  = hash_bkt;
          state_d = S_T_RDB;
        end
      end
      S_T_RDB: begin
        br_en   = 1'b1;
        state_d = S_T_WB;
      end
      S_T_WB: begin
        bh_d = br_head;
        bt_d = br_tail;
        if (br_head != NIL) begin
          sr_en   = 1'b1;
          sr_addr = br_head[SW-1:0];
          state_d = S_T_WS;
        end else begin
          state_d = S_T_NEXTB;
        end
      end
      S_T_WS: begin
        if (sr_time <= now_q) begin
          s_d      = bh_q[SW-1:0];
          ex_tag_d = sr_tag;
          bh_d     = sr_next;
          bt_d     = tail_after;
          bw_en    = 1'b1;
          bw_head  = sr_next;
          bw_tail  = tail_after;
          if (sr_next != NIL) begin
            sw_en   = 1'b1;
            sw_addr = sr_next[SW-1:0];
            sw_mask = '{time_en: 1'b0, tag_en: 1'b0, next_en: 1'b0, prev_en: 1'b1};
            sw_prev = NIL;
          end
          live_d[bh_q[SW-1:0]] = 1'b0;
          state_d = S_T_PUSH;
        end else begin
          state_d = S_T_NEXTB;
        end
      end
      S_T_PUSH: begin
        if (!pend_q || out_free) begin
          out_load  = pend_q;
          res_st_d  = ST_OK;
          res_hdl_d = s_q;
          res_tag_d = ex_tag_q;
          res_exp_d = 1'b1;
          pend_d    = 1'b1;
          if (bh_q != NIL) begin
            sr_en   = 1'b1;
            sr_addr = bh_q[SW-1:0];
            state_d = S_T_WS;
          end else begin
            state_d = S_T_NEXTB;
          end
        end
      end
      S_T_NEXTB: begin
        if (b_q == stop_q && (!first_q || !over_q)) begin
          if (!pend_q) begin
            res_st_d  = ST_OK;
            res_hdl_d = '0;
            res_tag_d = '0;
            res_exp_d = 1'b0;
          end
          pend_d  = 1'b0;
          state_d = S_EMIT;
        end else begin
          first_d = 1'b0;
          b_d     = (b_q == LAST_BKT) ? '0 : b_q + BW'(1);
          state_d = S_T_RDB;
        end
      end
      default: state_d = S_IDLE;
    endcase

    // insert and reschedule finish with one ok result
    if (link_done) begin
      res_st_d  = ST_OK;
      res_hdl_d = (cmd_q == CMD_INSERT) ? s_q : '0;
      res_tag_d = '0;
      res_exp_d = 1'b0;
      state_d   = S_EMIT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLR;
      clr_q     <= '0;
      now_q     <= '0;
      scan_q    <= '0;
      live_q    <= '0;
      pend_q    <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      now_q   <= now_d;
      scan_q  <= scan_d;
      live_q  <= live_d;
      pend_q  <= pend_d;
      if (out_load) m_valid_q <= 1'b1;
      else if (m_axis_tready_i) m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;   s_q <= s_d;       nt_q <= nt_d;       tag_q <= tag_d;
    b_q <= b_d;       stop_q <= stop_d; over_q <= over_d;   first_q <= first_d;
    bh_q <= bh_d;     bt_q <= bt_d;     p_q <= p_d;         pp_q <= pp_d;
    sn_q <= sn_d;     sp_q <= sp_d;     ex_tag_q <= ex_tag_d;
    res_st_q <= res_st_d; res_hdl_q <= res_hdl_d;
    res_tag_q <= res_tag_d; res_exp_q <= res_exp_d;
    if (out_load) begin
      m_st_q   <= res_st_q;
      m_hdl_q  <= res_hdl_q;
      m_tag_q  <= res_tag_q;
      m_exp_q  <= res_exp_q;
      m_last_q <= out_last;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {2'b00, m_tag_q, 6'(m_hdl_q)};
  assign m_axis_tuser_o  = {m_exp_q, m_st_q};
  assign m_axis_tlast_o  = m_last_q;

  // hash results only arrive while the sequencer waits for one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    hash_done |-> (state_q == S_INS_HASH || state_q == S_U_HASH || state_q == S_T_HASH))
    else $error("hash result outside a wait state");

  // no same-cycle read and write of one bucket entry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (br_en && bw_en) |-> (br_addr != bw_addr))
    else $error("bucket read and write collide");

  // no same-cycle read and write of one slot record
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sr_en && sw_en) |-> (sr_addr != sw_addr))
    else $error("slot read and write collide");

  // a tick leaves no held-back expiry behind
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |-> !pend_q)
    else $error("new transaction with an expiry still held");

endmodule

>>> sim/tb.sv
// testbench for hashed_timer_wheel_unit: directed and random timer commands
// checked against a behavioral wheel model kept inside the testbench
// depends on htw_pkg and the rtl of hashed_timer_wheel_unit

module tb;
  import htw_pkg::*;

  localparam int SLOTS    = 64;
  localparam int NBUCKETS = 1024;
  localparam int SHIFT    = 5;
  localparam int WATCHDOG = 50000;

  typedef struct {
    logic [1:0]  status;
    logic [5:0]  handle;
    logic [31:0] tag;
    logic        expired;
    logic        last;
  } timer_result_t;

  logic         clk_i;
  logic         rst_ni;
  logic         cmd_valid;
  logic [103:0] cmd_data;
  logic [1:0]   cmd_kind;
  logic         res_ready;
  logic         s_axis_tready_o;
  logic         m_axis_tvalid_o;
  logic [39:0]  m_axis_tdata_o;
  logic [2:0]   m_axis_tuser_o;
  logic         m_axis_tlast_o;

  hashed_timer_wheel_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (cmd_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (cmd_data),
    .s_axis_tuser_i  (cmd_kind),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (res_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  // wheel model state
  logic [31:0]   wheel_now;
  int            wheel_scan;
  bit            timer_live [SLOTS];
  logic [31:0]   timer_due  [SLOTS];
  logic [31:0]   timer_tag  [SLOTS];
  int            bucket_list [NBUCKETS][$];
  timer_result_t pending_results[$];

  int  mismatches;
  int  quiet_cycles;
  bit  idling_on;
  int  stall_left;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic logic [31:0] sat_sum(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hffff_ffff : s[31:0];
  endfunction

  function automatic int bucket_of(logic [31:0] t);
    return int'((t >> SHIFT) % NBUCKETS);
  endfunction

  function automatic void push_result(logic [1:0] st, int h, logic [31:0] tg, bit ex);
    timer_result_t r;
    r.status = st; r.handle = h[5:0]; r.tag = tg; r.expired = ex; r.last = 1'b1;
    pending_results.push_back(r);
  endfunction

  // sorted insert, equal times stay in arrival order
  function automatic void link_timer(int s);
    int b;
    int pos;
    b = bucket_of(timer_due[s]);
    pos = 0;
    while (pos < bucket_list[b].size() && timer_due[bucket_list[b][pos]] <= timer_due[s])
      pos++;
    bucket_list[b].insert(pos, s);
  endfunction

  function automatic void unlink_timer(int s);
    int b;
    b = bucket_of(timer_due[s]);
    foreach (bucket_list[b][i]) begin
      if (bucket_list[b][i] == s) begin
        bucket_list[b].delete(i);
        break;
      end
    end
  endfunction

  function automatic int drain_bucket(int b, int k);
    int s;
    while (bucket_list[b].size() > 0 && timer_due[bucket_list[b][0]] <= wheel_now && k < SLOTS)
    begin
      s = bucket_list[b].pop_front();
      timer_live[s] = 1'b0;
      push_result(ST_OK, s, timer_tag[s], 1'b1);
      pending_results[pending_results.size()-1].last = 1'b0;
      k++;
    end
    return k;
  endfunction

  // expected results of one accepted command
  function automatic void predict_wheel(logic [1:0] cmd, logic [5:0] h, logic [30:0] dly,
                                        logic [31:0] elapsed, logic [31:0] tg);
    int s;
    int b;
    int stop;
    int k;
    bit over;
    case (cmd)
      CMD_INSERT: begin
        if (dly == 0) begin
          push_result(ST_ZERO, 0, 0, 1'b0);
          return;
        end
        s = 0;
        while (s < SLOTS && timer_live[s]) s++;
        if (s >= SLOTS) begin
          push_result(ST_FULL, 0, 0, 1'b0);
          return;
        end
        timer_live[s] = 1'b1;
        timer_tag[s] = tg;
        timer_due[s] = sat_sum(wheel_now, {1'b0, dly});
        link_timer(s);
        push_result(ST_OK, s, 0, 1'b0);
      end
      CMD_CANCEL, CMD_RESCHED: begin
        if (!timer_live[h]) begin
          push_result(ST_DEAD, 0, 0, 1'b0);
          return;
        end
        if (cmd == CMD_RESCHED && dly == 0) begin
          push_result(ST_ZERO, 0, 0, 1'b0);
          return;
        end
        unlink_timer(h);
        if (cmd == CMD_CANCEL) begin
          timer_live[h] = 1'b0;
        end else begin
          timer_due[h] = sat_sum(wheel_now, {1'b0, dly});
          link_timer(h);
        end
        push_result(ST_OK, 0, 0, 1'b0);
      end
      default: begin
        b = wheel_scan;
        over = (elapsed >> SHIFT) >= NBUCKETS;
        wheel_now = sat_sum(wheel_now, elapsed);
        stop = over ? b : bucket_of(wheel_now);
        k = drain_bucket(b, 0);
        if (b != stop || over) begin
          wheel_scan = stop;
          do begin
            b = (b + 1) % NBUCKETS;
            k = drain_bucket(b, k);
          end while (b != stop);
        end
        if (k == 0) push_result(ST_OK, 0, 0, 1'b0);
        else pending_results[pending_results.size()-1].last = 1'b1;
      end
    endcase
  endfunction

  // one command transaction, with an optional idle burst in front
  task automatic send_command(logic [1:0] cmd, logic [5:0] h, logic [30:0] dly,
                              logic [31:0] elapsed, logic [31:0] tg);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      cmd_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    cmd_valid <= 1'b1;
    cmd_kind  <= cmd;
    cmd_data  <= {3'b0, tg, elapsed, dly, h};
    do @(posedge clk_i); while (!s_axis_tready_o);
    predict_wheel(cmd, h, dly, elapsed, tg);
  endtask

  task automatic wait_results_done();
    cmd_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  function automatic int pick_live();
    int q[$];
    foreach (timer_live[i]) if (timer_live[i]) q.push_back(i);
    return q.size() ? q[$urandom_range(0, q.size() - 1)] : $urandom_range(0, SLOTS - 1);
  endfunction

  // result side: random stall bursts and field checks
  always @(posedge clk_i) begin
    timer_result_t e;
    if (rst_ni && m_axis_tvalid_o && res_ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result transaction");
        mismatches++;
      end else begin
        e = pending_results.pop_front();
        if (m_axis_tuser_o[1:0] !== e.status) begin
          $error("status expected %0d actual %0d", e.status, m_axis_tuser_o[1:0]);
          mismatches++;
        end
        if (m_axis_tdata_o[5:0] !== e.handle) begin
          $error("out_handle expected %0d actual %0d", e.handle, m_axis_tdata_o[5:0]);
          mismatches++;
        end
        if (m_axis_tdata_o[37:6] !== e.tag) begin
          $error("out_tag expected %h actual %h", e.tag, m_axis_tdata_o[37:6]);
          mismatches++;
        end
        if (m_axis_tuser_o[2] !== e.expired) begin
          $error("expired expected %0d actual %0d", e.expired, m_axis_tuser_o[2]);
          mismatches++;
        end
        if (m_axis_tlast_o !== e.last) begin
          $error("last expected %0d actual %0d", e.last, m_axis_tlast_o);
          mismatches++;
        end
      end
    end
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      res_ready <= 1'b0;
    end else if (idling_on && $urandom_range(0, 4) == 0) begin
      stall_left <= $urandom_range(0, 4);
      res_ready <= 1'b0;
    end else begin
      res_ready <= 1'b1;
    end
  end

  // watchdog on cycles where neither side moves a transaction
  always @(posedge clk_i) begin
    if ((cmd_valid && s_axis_tready_o) || (m_axis_tvalid_o && res_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic test_single_commands();
    send_command(CMD_INSERT, 0, 1, 0, 32'h0);
    send_command(CMD_INSERT, 0, 31'h7fff_ffff, 0, 32'hffff_ffff);
    send_command(CMD_INSERT, 0, 0, 0, 32'h1234);
    send_command(CMD_INSERT, 0, 100, 0, 32'hdead_beef);
    send_command(CMD_CANCEL, 2, 0, 0, 0);
    send_command(CMD_CANCEL, 2, 0, 0, 0);
    send_command(CMD_CANCEL, 63, 0, 0, 0);
    send_command(CMD_RESCHED, 1, 0, 0, 0);
    send_command(CMD_RESCHED, 63, 0, 0, 0);
    send_command(CMD_RESCHED, 1, 50, 0, 0);
    send_command(CMD_TICK, 0, 0, 0, 0);
    send_command(CMD_TICK, 0, 0, 1, 0);
    send_command(CMD_TICK, 0, 0, 60, 0);
    send_command(CMD_INSERT, 0, 5, 0, 32'ha5a5_5a5a);
    send_command(CMD_INSERT, 0, 5, 0, 32'h5a5a_a5a5);
    send_command(CMD_TICK, 0, 0, 5, 0);
  endtask

  // fill the pool, hit the full case, then expire everything in one wrapping tick
  task automatic test_pool_full();
    for (int i = 0; i < SLOTS; i++)
      send_command(CMD_INSERT, 0, 31'(100000 + ($urandom_range(0, 3) * 37)), 0, $urandom);
    send_command(CMD_INSERT, 0, 10, 0, 32'h1);
    send_command(CMD_INSERT, 0, 0, 0, 32'h1);
    send_command(CMD_TICK, 0, 0, 32'd200000, 0);
  endtask

  task automatic test_random(int count);
    logic [1:0]  cmd;
    logic [5:0]  h;
    logic [30:0] dly;
    logic [31:0] el;
    int          pick;
    for (int n = 0; n < count; n++) begin
      if (n == count - 60) idling_on = 1'b0;
      if (n == count / 2) wait_results_done();
      pick = $urandom_range(0, 99);
      cmd = pick < 35 ? CMD_INSERT : pick < 50 ? CMD_CANCEL : pick < 65 ? CMD_RESCHED : CMD_TICK;
      h = $urandom_range(0, 9) < 8 ? 6'(pick_live()) : 6'($urandom_range(0, SLOTS - 1));
      pick = $urandom_range(0, 99);
      dly = pick < 5 ? 31'd0 : pick < 80 ? 31'($urandom_range(1, 3000)) :
            pick < 95 ? 31'($urandom_range(1, 1 << 20)) : 31'($urandom);
      pick = $urandom_range(0, 99);
      el = pick < 10 ? 32'd0 : pick < 97 ? 32'($urandom_range(1, 400)) :
           32'($urandom_range(1000, 40000));
      send_command(cmd, h, dly, el, $urandom);
    end
  endtask

  // time counter and expiry times pinned at the maximum
  task automatic test_saturation();
    send_command(CMD_INSERT, 0, 31'h7fff_ffff, 0, 32'hcafe_f00d);
    send_command(CMD_TICK, 0, 0, 32'hffff_ffff, 0);
    send_command(CMD_INSERT, 0, 1, 0, 32'h0bad_cafe);
    send_command(CMD_RESCHED, 0, 31'h4000_0000, 0, 0);
    send_command(CMD_TICK, 0, 0, 0, 0);
  endtask

  initial begin
    cmd_valid = 1'b0;
    cmd_data = '0;
    cmd_kind = CMD_INSERT;
    res_ready = 1'b0;
    rst_ni = 1'b0;
    mismatches = 0;
    quiet_cycles = 0;
    stall_left = 0;
    idling_on = 1'b1;
    wheel_now = 0;
    wheel_scan = 0;
    foreach (timer_live[i]) timer_live[i] = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_single_commands();
    test_pool_full();
    test_random(345);
    test_saturation();
    wait_results_done();
    repeat (100) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/htw_pkg.sv
rtl/htw_slot_mem.sv
rtl/htw_bucket_mem.sv
rtl/htw_hash.sv
rtl/hashed_timer_wheel_unit.sv
sim/tb.sv
